// ===== sv/bblur_pkg.sv =====
// Shared types, sizes and constants for the 3x3 box blur block.
`default_nettype none

package bblur_pkg;

    // Frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    // Register and counter widths
    localparam int FW_W       = 11;                       // frame_width register
    localparam int FH_W       = 13;                       // frame_height register
    localparam int CFG_DATA_W = 13;                       // widest register
    localparam int CFG_IDX_W  = 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);        // column index
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 3);   // row count, saturates at max + 2

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    // Register reset values
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Sum of nine bytes and the reciprocal used to divide it by nine
    localparam int SUM_W      = $clog2(9 * 255 + 1);
    localparam int DIV9_MUL_W = 13;
    localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;   // ceil(2^16 / 9)
    localparam int DIV9_SHIFT = 16;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic [23:0] rgb_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] in_pixel;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_pixel;
        logic        frame_last;
    } out_item_t;

    // Per-item control carried alongside the pixel data
    typedef struct packed {
        logic emit;
        logic col_left;
        logic col_right;
        logic row_top;
        logic row_bottom;
        logic last;
    } tap_ctl_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } rgb_sum_t;

endpackage

`default_nettype wire

// ===== sv/bblur_line_store.sv =====
// Two-row line store in one memory, read-modify-write with same-address forwarding.
`default_nettype none

module bblur_line_store (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        rd_en,
    input  wire logic [bblur_pkg::COL_W-1:0] rd_addr,
    input  wire bblur_pkg::rgb_t             fresh_in,
    input  wire bblur_pkg::tap_ctl_t         ctl_in,
    output logic                             col_valid,
    output bblur_pkg::rgb_t                  col_top,
    output bblur_pkg::rgb_t                  col_mid,
    output bblur_pkg::rgb_t                  col_fresh,
    output bblur_pkg::tap_ctl_t              col_ctl
);
    import bblur_pkg::*;

    // Entry holds {upper row, middle row} for one column
    logic [47:0]      mem [MAX_WIDTH];
    logic [47:0]      rd_data_reg;
    logic [47:0]      fwd_data_reg;
    logic             fwd_reg;
    logic             valid_reg;
    logic [COL_W-1:0] addr_reg;
    rgb_t             fresh_reg;
    tap_ctl_t         ctl_reg;
    logic [47:0]      entry;
    logic [47:0]      wr_data;

    // Previous item wrote this entry on the edge we read it: take its data
    assign entry   = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign wr_data = {entry[23:0], fresh_reg};

    assign col_valid = valid_reg;
    assign col_top   = entry[47:24];
    assign col_mid   = entry[23:0];
    assign col_fresh = fresh_reg;
    assign col_ctl   = ctl_reg;

    // Memory: read on accept, write back in the next cycle
    always_ff @(posedge aclk) begin
        if (valid_reg) begin
            mem[addr_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            addr_reg     <= rd_addr;
            fresh_reg    <= fresh_in;
            ctl_reg      <= ctl_in;
            fwd_reg      <= valid_reg && (addr_reg == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bblur_window.sv =====
// 3x3 window registers and the masked per-channel neighbourhood sums.
`default_nettype none

module bblur_window (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                col_valid,
    input  wire bblur_pkg::rgb_t     col_top,
    input  wire bblur_pkg::rgb_t     col_mid,
    input  wire bblur_pkg::rgb_t     col_fresh,
    input  wire bblur_pkg::tap_ctl_t col_ctl,
    output logic                     sum_valid,
    output bblur_pkg::rgb_sum_t      sum,
    output logic                     sum_last
);
    import bblur_pkg::*;

    // win_reg[column][row]: column 0 left, row 0 top
    rgb_t             win_reg [3][3];
    logic             c_valid_reg;
    tap_ctl_t         c_ctl_reg;
    logic             d_valid_reg;
    rgb_sum_t         d_sum_reg;
    logic             d_last_reg;
    logic [2:0]       col_ok;
    logic [2:0]       row_ok;
    logic [SUM_W-1:0] col_part [3][3];   // [channel][column]
    rgb_sum_t         sum_c;

    // Shift the window left and load the new right-hand column
    always_ff @(posedge aclk) begin
        if (col_valid) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2][0] <= col_top;
            win_reg[2][1] <= col_mid;
            win_reg[2][2] <= col_fresh;
            c_ctl_reg <= col_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= col_valid && col_ctl.emit;
            d_valid_reg <= c_valid_reg;
        end
    end

    // Masked sums: per column first, then across columns
    always_comb begin
        col_ok = {c_ctl_reg.col_right, 1'b1, c_ctl_reg.col_left};
        row_ok = {c_ctl_reg.row_bottom, 1'b1, c_ctl_reg.row_top};
        for (int ch = 0; ch < 3; ch++) begin
            for (int c = 0; c < 3; c++) begin
                col_part[ch][c] = '0;
                for (int r = 0; r < 3; r++) begin
                    if (col_ok[c] && row_ok[r]) begin
                        col_part[ch][c] = col_part[ch][c]
                            + SUM_W'(win_reg[c][r][16 - 8 * ch +: 8]);
                    end
                end
            end
        end
        sum_c.red   = col_part[0][0] + col_part[0][1] + col_part[0][2];
        sum_c.green = col_part[1][0] + col_part[1][1] + col_part[1][2];
        sum_c.blue  = col_part[2][0] + col_part[2][1] + col_part[2][2];
    end

    always_ff @(posedge aclk) begin
        if (c_valid_reg) begin
            d_sum_reg  <= sum_c;
            d_last_reg <= c_ctl_reg.last;
        end
    end

    assign sum_valid = d_valid_reg;
    assign sum       = d_sum_reg;
    assign sum_last  = d_last_reg;

endmodule

`default_nettype wire

// ===== sv/bblur_div9.sv =====
// Divide each channel sum by nine via reciprocal multiply and pack the output word.
`default_nettype none

module bblur_div9 (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                sum_valid,
    input  wire bblur_pkg::rgb_sum_t sum,
    input  wire logic                sum_last,
    output logic                     px_valid,
    output bblur_pkg::out_item_t     px_item
);
    import bblur_pkg::*;

    localparam int PROD_W = SUM_W + DIV9_MUL_W;

    logic              valid_reg;
    out_item_t         item_reg;
    logic [PROD_W-1:0] prod_r;
    logic [PROD_W-1:0] prod_g;
    logic [PROD_W-1:0] prod_b;

    // Exact floor(x / 9) for x up to 9 * 255
    assign prod_r = PROD_W'(sum.red)   * PROD_W'(DIV9_MUL);
    assign prod_g = PROD_W'(sum.green) * PROD_W'(DIV9_MUL);
    assign prod_b = PROD_W'(sum.blue)  * PROD_W'(DIV9_MUL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_valid) begin
            item_reg.out_pixel  <= {prod_r[DIV9_SHIFT +: 8], prod_g[DIV9_SHIFT +: 8],
                                    prod_b[DIV9_SHIFT +: 8], ALPHA_OPAQUE};
            item_reg.frame_last <= sum_last;
        end
    end

    assign px_valid = valid_reg;
    assign px_item  = item_reg;

endmodule

`default_nettype wire

// ===== sv/bblur_out_fifo.sv =====
// Small output queue that decouples the blur pipeline from the result receiver.
`default_nettype none

module bblur_out_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire bblur_pkg::out_item_t push_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output bblur_pkg::out_item_t      m_item
);
    import bblur_pkg::*;

    out_item_t             slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  pop;

    // Space is reserved upstream, so a push never meets a full queue
    assign m_valid = (count_reg != '0);
    assign m_item  = slot_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/box_blur_3x3_rgb.sv =====
// Streaming 3x3 box blur over RGBA8888 frames: top level with counters and flow control.
//
// Usage:
//   s_valid/s_ready/s_item carry pixel items (kind 0) or flush items (kind 1) in
//   raster order. m_valid/m_ready/m_item carry blurred pixels, alpha 0xFF, with
//   frame_last set on the final pixel of each frame. After a frame's pixels the
//   host sends frame_width + 1 flush items to release the remaining outputs.
//   frame_width and frame_height are written through cfg_wr_en/cfg_index/cfg_wdata
//   while the block is idle; they reset to 640 x 480.
//   Path: a releasing item is registered in the line store, window, sum, divider
//   and queue before m_*; output lags input by one row plus one pixel.
//   Throughput: one item per cycle while the queue has room. The line store is a
//   single 1024 x 48 memory read on accept and written back in the next cycle, with
//   forwarding on same-column hits, so it takes one access pair per item.
//   Stalls: results queue in an 8-entry output FIFO. Input is taken as long as
//   fewer than 8 results are queued or in flight, so a stalled receiver stops the
//   input only once that queue is full; nothing is lost or dropped.
//   Reset (aresetn low, synchronous) empties the pipeline and queue and returns
//   all counters to the start of a frame. No clearing pass is needed.
`default_nettype none

module box_blur_3x3_rgb (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire bblur_pkg::in_item_t             s_item,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output bblur_pkg::out_item_t                 m_item,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bblur_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bblur_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import bblur_pkg::*;

    localparam logic [FW_W-1:0]  W_MAX  = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0]  H_MAX  = FH_W'(MAX_HEIGHT);
    localparam logic [ROW_W-1:0] IR_SAT = ROW_W'(MAX_HEIGHT + 2);

    logic [FW_W-1:0]       frame_width_reg;
    logic [FH_W-1:0]       frame_height_reg;
    logic [COL_W-1:0]      in_col_reg,  in_col_next;
    logic [ROW_W-1:0]      in_row_reg,  in_row_next;
    logic [COL_W-1:0]      out_col_reg, out_col_next;
    logic [ROW_W-1:0]      out_row_reg, out_row_next;
    logic [FIFO_CNT_W-1:0] reserved_reg, reserved_next;

    logic [FW_W-1:0]  w;
    logic [FH_W-1:0]  h;
    logic [COL_W:0]   in_col_inc;
    logic [COL_W:0]   out_col_inc;
    logic [ROW_W-1:0] out_row_inc;
    logic             accept;
    logic             emit;
    rgb_t             fresh;
    tap_ctl_t         ctl;

    logic                col_valid;
    rgb_t                col_top, col_mid, col_fresh;
    tap_ctl_t            col_ctl;
    logic                sum_valid;
    rgb_sum_t            sum;
    logic                sum_last;
    logic                px_valid;
    out_item_t           px_item;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FW_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FH_W-1:0];
                default:          ;
            endcase
        end
    end

    // Frame sizes saturated to the supported range
    always_comb begin
        if (frame_width_reg == '0) begin
            w = FW_W'(1);
        end else if (frame_width_reg > W_MAX) begin
            w = W_MAX;
        end else begin
            w = frame_width_reg;
        end
        if (frame_height_reg == '0) begin
            h = FH_W'(1);
        end else if (frame_height_reg > H_MAX) begin
            h = H_MAX;
        end else begin
            h = frame_height_reg;
        end
    end

    // Flow control: keep a slot in the output queue for every result in flight
    assign s_ready = (reserved_reg < FIFO_CNT_W'(FIFO_DEPTH));
    assign accept  = s_valid && s_ready;

    // Per-item decode, window masks and end of frame
    always_comb begin
        in_col_inc  = {1'b0, in_col_reg} + 1'b1;
        out_col_inc = {1'b0, out_col_reg} + 1'b1;
        out_row_inc = out_row_reg + 1'b1;

        emit = (in_row_reg >= ROW_W'(2))
            || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));

        if (!s_item.kind && (ROW_W'(in_row_reg) < ROW_W'(h))) begin
            fresh = s_item.in_pixel[31:8];
        end else begin
            fresh = '0;
        end

        ctl.emit       = emit;
        ctl.col_left   = (out_col_reg != '0);
        ctl.col_right  = (FW_W'(out_col_inc) < w);
        ctl.row_top    = (out_row_reg != '0);
        ctl.row_bottom = (ROW_W'(out_row_inc) < ROW_W'(h));
        ctl.last       = (ROW_W'(out_row_inc) >= ROW_W'(h)) && (FW_W'(out_col_inc) >= w);
    end

    // Input and output position counters
    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (accept) begin
            if (FW_W'(in_col_inc) >= w) begin
                in_col_next = '0;
                if (in_row_reg < IR_SAT) begin
                    in_row_next = in_row_reg + 1'b1;
                end
            end else begin
                in_col_next = in_col_inc[COL_W-1:0];
            end
            if (emit) begin
                if (ctl.last) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end else if (FW_W'(out_col_inc) >= w) begin
                    out_col_next = '0;
                    out_row_next = out_row_inc;
                end else begin
                    out_col_next = out_col_inc[COL_W-1:0];
                end
            end
        end
    end

    // Reserved output slots
    always_comb begin
        reserved_next = reserved_reg;
        if (accept && emit) begin
            reserved_next = reserved_next + 1'b1;
        end
        if (m_valid && m_ready) begin
            reserved_next = reserved_next - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            reserved_reg <= '0;
        end else begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            reserved_reg <= reserved_next;
        end
    end

    bblur_line_store u_line_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_addr   (in_col_reg),
        .fresh_in  (fresh),
        .ctl_in    (ctl),
        .col_valid (col_valid),
        .col_top   (col_top),
        .col_mid   (col_mid),
        .col_fresh (col_fresh),
        .col_ctl   (col_ctl)
    );

    bblur_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .col_valid (col_valid),
        .col_top   (col_top),
        .col_mid   (col_mid),
        .col_fresh (col_fresh),
        .col_ctl   (col_ctl),
        .sum_valid (sum_valid),
        .sum       (sum),
        .sum_last  (sum_last)
    );

    bblur_div9 u_div9 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sum_valid (sum_valid),
        .sum       (sum),
        .sum_last  (sum_last),
        .px_valid  (px_valid),
        .px_item   (px_item)
    );

    bblur_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (px_valid),
        .push_item (px_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

`default_nettype wire
